/* sv/sec_pkg.sv */
// Shared types and constants for the scope edge-trigger capture block.
package sec_pkg;

  // Largest capture the block supports, and the widths that follow from it.
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int LEN_W       = 11;
  localparam int SMP_W       = 16;

  // Configuration port widths.
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE  = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH = CFG_ADDR_W'(3);

  // Trigger modes; the unused code behaves like software mode.
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_ALWAYS   = 2'd1;
  localparam logic [1:0] MODE_SOFTWARE = 2'd2;

  localparam logic SLOPE_RISING = 1'b0;

  // Input actions.
  localparam logic ACT_SAMPLE   = 1'b0;
  localparam logic ACT_SOFTWARE = 1'b1;

  // Reset values and length limits.
  localparam logic [SMP_W-1:0] RESET_LEVEL  = SMP_W'(1000);
  localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(512);
  localparam logic [LEN_W-1:0] MIN_LENGTH   = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LENGTH   = LEN_W'(MAX_SAMPLES);

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One result item.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] position;
    logic [SMP_W-1:0] captured;
  } res_t;

  // Results produced by the front for one accepted beat.
  typedef struct packed {
    logic [1:0] count;
    res_t       r1;
    res_t       r0;
  } push_t;

endpackage

/* sv/sec_front.sv */
// Front part: configuration registers, trigger detection and capture state.
module sec_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [sec_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_fire,
  input  logic                            in_action,
  input  logic [sec_pkg::SMP_W-1:0]       in_sample,
  output sec_pkg::push_t                  push
);

  logic [1:0]                 mode_r, mode_nxt;
  logic                       slope_r, slope_nxt;
  logic [sec_pkg::SMP_W-1:0]  level_r, level_nxt;
  logic [sec_pkg::LEN_W-1:0]  length_r, length_nxt;
  logic                       capturing_r, capturing_nxt;
  logic [sec_pkg::IDX_W-1:0]  widx_r, widx_nxt;
  logic [sec_pkg::SMP_W-1:0]  prev_r, prev_nxt;

  logic [sec_pkg::LEN_W-1:0]  len_raw;
  logic [sec_pkg::LEN_W-1:0]  len_clamped;
  logic                       fin_run;
  logic                       fin_trig;
  logic                       hit;

  assign len_raw = cfg_data[sec_pkg::LEN_W-1:0];

  always_comb begin
    if (len_raw > sec_pkg::MAX_LENGTH) begin
      len_clamped = sec_pkg::MAX_LENGTH;
    end else if (len_raw < sec_pkg::MIN_LENGTH) begin
      len_clamped = sec_pkg::MIN_LENGTH;
    end else begin
      len_clamped = len_raw;
    end
  end

  // The sample at the current index ends the capture when the index reaches length - 1.
  assign fin_run  = ({1'b0, widx_r} + sec_pkg::LEN_W'(1)) >= length_r;
  assign fin_trig = (length_r == sec_pkg::MIN_LENGTH);

  always_comb begin
    if (slope_r == sec_pkg::SLOPE_RISING) begin
      hit = (prev_r < level_r) && (level_r < in_sample);
    end else begin
      hit = (prev_r > level_r) && (level_r > in_sample);
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    slope_nxt     = slope_r;
    level_nxt     = level_r;
    length_nxt    = length_r;
    capturing_nxt = capturing_r;
    widx_nxt      = widx_r;
    prev_nxt      = prev_r;
    push          = '0;

    if (cfg_valid) begin
      // Any write to a known register aborts a running capture.
      case (cfg_addr)
        sec_pkg::REG_MODE: begin
          mode_nxt      = cfg_data[1:0];
          capturing_nxt = 1'b0;
          widx_nxt      = '0;
        end
        sec_pkg::REG_SLOPE: begin
          slope_nxt     = cfg_data[0];
          capturing_nxt = 1'b0;
          widx_nxt      = '0;
        end
        sec_pkg::REG_LEVEL: begin
          level_nxt     = cfg_data;
          capturing_nxt = 1'b0;
          widx_nxt      = '0;
        end
        sec_pkg::REG_LENGTH: begin
          length_nxt    = len_clamped;
          capturing_nxt = 1'b0;
          widx_nxt      = '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (in_action == sec_pkg::ACT_SOFTWARE) begin
        capturing_nxt = 1'b1;
        widx_nxt      = '0;
      end else if (capturing_r) begin
        push.count       = 2'd1;
        push.r0.captured = in_sample;
        push.r0.position = widx_r;
        push.r0.last     = fin_run;
        if (fin_run) begin
          capturing_nxt = (mode_r == sec_pkg::MODE_ALWAYS);
          widx_nxt      = '0;
        end else begin
          widx_nxt = widx_r + sec_pkg::IDX_W'(1);
        end
      end else begin
        prev_nxt = in_sample;
        if (mode_r == sec_pkg::MODE_NORMAL) begin
          if (hit) begin
            push.count       = 2'd2;
            push.r0.captured = prev_r;
            push.r0.position = '0;
            push.r0.last     = 1'b0;
            push.r1.captured = in_sample;
            push.r1.position = sec_pkg::IDX_W'(1);
            push.r1.last     = fin_trig;
            capturing_nxt    = !fin_trig;
            widx_nxt         = fin_trig ? '0 : sec_pkg::IDX_W'(2);
          end
        end else if (mode_r == sec_pkg::MODE_ALWAYS) begin
          capturing_nxt = 1'b1;
          widx_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sec_pkg::MODE_NORMAL;
      slope_r     <= sec_pkg::SLOPE_RISING;
      level_r     <= sec_pkg::RESET_LEVEL;
      length_r    <= sec_pkg::RESET_LENGTH;
      capturing_r <= 1'b0;
      widx_r      <= '0;
      prev_r      <= '0;
    end else begin
      mode_r      <= mode_nxt;
      slope_r     <= slope_nxt;
      level_r     <= level_nxt;
      length_r    <= length_nxt;
      capturing_r <= capturing_nxt;
      widx_r      <= widx_nxt;
      prev_r      <= prev_nxt;
    end
  end

endmodule

/* sv/sec_queue.sv */
// Back part: queue that takes up to two results a cycle, drains one when out_ready.
module sec_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  sec_pkg::push_t  push,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output sec_pkg::res_t   out_res
);

  sec_pkg::res_t              mem_r [sec_pkg::QDEPTH];
  logic [sec_pkg::QPTR_W-1:0] wr_r, wr_nxt;
  logic [sec_pkg::QPTR_W-1:0] rd_r, rd_nxt;
  logic [sec_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [sec_pkg::QPTR_W-1:0] wr_plus1;
  logic                       pop;

  // Room for two results must stay free so any beat can be accepted.
  assign space     = cnt_r <= sec_pkg::QCNT_W'(sec_pkg::QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_plus1  = wr_r + sec_pkg::QPTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + sec_pkg::QPTR_W'(push.count);
    rd_nxt  = pop ? rd_r + sec_pkg::QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + sec_pkg::QCNT_W'(push.count) - sec_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_plus1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/scope_edge_trigger_capture.sv */
// Top level of the oscilloscope edge-trigger capture block.
//
//  Channel  Direction  Payload                                 Handshake
//  in_      slave      tdata: sample; tuser: action            in_tvalid / in_tready
//  out_     master     tdata: captured, position; tlast: last  out_tvalid / out_tready
//  cfg_     slave      cfg_addr: register index; cfg_data      cfg_valid / cfg_ready
//
// One input beat is taken per cycle while in_tready is high; a beat is
// classified and the capture state updated in that cycle; its results leave
// a four-entry queue from the next cycle on, one per cycle as out_tready allows.
// A crossing yields two results from one beat; in_tready drops while fewer
// than two queue entries are free, so the queue drain sets the sustained rate.
// Reset (rst_n, synchronous) returns the registers to normal mode, rising
// slope, level 1000 mV and length 512, and empties the queue.
// Configuration writes are always taken (cfg_ready is tied high), and in_tready
// is held low in a cycle that offers a write, so no input beat is lost to it.
module scope_edge_trigger_capture (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input beats.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample
  input  logic                            in_tuser,   // [0] action
  // Result beats.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [15:0] captured, [25:16] position
  output logic                            out_tlast,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sec_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sec_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sec_pkg::push_t push;
  sec_pkg::res_t  head;
  logic           space;
  logic           in_fire;

  assign cfg_ready = 1'b1;
  // A register write takes the cycle, so the input side waits for it.
  assign in_tready = space && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;

  // Front: registers, trigger test and capture index.
  sec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_action (in_tuser),
    .in_sample (in_tdata),
    .push      (push)
  );

  // Back: queue that decouples result delivery from beat acceptance.
  sec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // Pack the result: captured in the low bits, position above, zero filled.
  assign out_tdata = {6'd0, head.position, head.captured};
  assign out_tlast = head.last;

endmodule
